// File: design/assert_macros.svh
// Shared assertion macros for the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  `ASSERT_PROP(lbl, clk, rstn, (ante) |-> (cons))

`endif

// File: design/tmsd_pkg.sv
package tmsd_pkg;

  // Range and offsets of the conversion
  localparam logic [14:0]        SENSOR_MAX = 15'd28800;
  localparam logic signed [10:0] C_OFFSET   = 11'sd450;
  localparam logic signed [13:0] F_OFFSET   = 14'sd320;
  localparam logic signed [13:0] C_LIMIT    = 14'sd450;
  localparam logic signed [13:0] F_HIGH     = 14'sd1130;
  localparam logic signed [13:0] F_LOW      = -14'sd490;

  // Segment codes and unit marks
  localparam logic [6:0] SEG_E      = 7'b0110111;
  localparam logic [6:0] SEG_R      = 7'b1011111;
  localparam logic [6:0] SEG_MINUS  = 7'b0000100;
  localparam int unsigned UNIT_C_BIT = 28;
  localparam int unsigned UNIT_F_BIT = 29;

  localparam logic [29:0] ERR_WORD = {2'b00, SEG_E, SEG_R, SEG_R, 7'b0000000};

  typedef logic [3:0] digit_t;

  // Map one decimal digit to its segment pattern
  function automatic logic [6:0] seg7(input digit_t d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'b1111011;
      4'd1:    s = 7'b1001000;
      4'd2:    s = 7'b0111101;
      4'd3:    s = 7'b1101101;
      4'd4:    s = 7'b1001110;
      4'd5:    s = 7'b1100111;
      4'd6:    s = 7'b1110111;
      4'd7:    s = 7'b1001001;
      4'd8:    s = 7'b1111111;
      4'd9:    s = 7'b1101111;
      default: s = 7'b0000000;
    endcase
    return s;
  endfunction

endpackage

// File: design/thermometer_seven_segment_display.sv
// Converts one raw sensor reading per cycle into a seven-segment display word
// (Celsius or Fahrenheit tenths, or ERR with fault set) through an eight-stage
// pipeline: offset and rounding, times nine, magnitude, divide by five, offset
// and range check, then three stages that split the magnitude into decimal
// digits with constant reciprocal multiplies and encode the segments. The
// throughput of one reading per cycle holds while the output is not stalled.
// A stall on the output backs up only as far as the pipeline is full, so empty
// stages still take new readings while a result waits.
module thermometer_seven_segment_display
  import tmsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] sensor_value_i,
  input  logic [7:0]  status_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [29:0] display_word_o,
  output logic        fault_o
);

  localparam int unsigned NSTAGE = 8;

  logic [NSTAGE:1] valid_q;
  logic [NSTAGE:1] adv;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    adv[NSTAGE] = !valid_q[NSTAGE] || !out_stall_i;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign in_stall_o = !adv[1];

  // Move valid bits along with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[1]) valid_q[1] <= in_valid_i;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (adv[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // Stage 1: range check, offset and rounding to Celsius tenths
  logic               err1_d, err1_q, fahr1_q;
  logic signed [10:0] t1_d, t1_q;

  always_comb begin
    err1_d = sensor_value_i[15] || (sensor_value_i[14:0] > SENSOR_MAX) || status_bits_i[2];
    t1_d   = $signed({1'b0, sensor_value_i[14:5]}) - C_OFFSET
           + $signed({10'd0, sensor_value_i[4]});
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      err1_q  <= err1_d;
      fahr1_q <= status_bits_i[5];
      t1_q    <= t1_d;
    end
  end

  // Stage 2: times nine for Fahrenheit
  logic               err2_q, fahr2_q;
  logic signed [13:0] t1_ext, p2_d, p2_q;

  always_comb begin
    t1_ext = {{3{t1_q[10]}}, t1_q};
    p2_d   = fahr1_q ? (t1_ext <<< 3) + t1_ext : t1_ext;
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      err2_q  <= err1_q;
      fahr2_q <= fahr1_q;
      p2_q    <= p2_d;
    end
  end

  // Stage 3: split into sign and magnitude
  logic        err3_q, fahr3_q, neg3_q;
  logic [12:0] pm3_d, pm3_q;

  assign pm3_d = p2_q[13] ? 13'(-p2_q) : p2_q[12:0];

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      err3_q  <= err2_q;
      fahr3_q <= fahr2_q;
      neg3_q  <= p2_q[13];
      pm3_q   <= pm3_d;
    end
  end

  // Stage 4: divide the magnitude by five for Fahrenheit (truncates toward zero)
  logic        err4_q, fahr4_q, neg4_q;
  logic [28:0] prod4;
  logic [12:0] q4_d, q4_q;

  always_comb begin
    prod4 = 29'(pm3_q) * 29'd52429;
    q4_d  = fahr3_q ? {2'b00, prod4[28:18]} : pm3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      err4_q  <= err3_q;
      fahr4_q <= fahr3_q;
      neg4_q  <= neg3_q;
      q4_q    <= q4_d;
    end
  end

  // Stage 5: restore sign, add Fahrenheit offset, check displayed range
  logic               err5_d, err5_q, fahr5_q, neg5_q;
  logic signed [13:0] q4_ext, v5;
  logic [10:0]        mag5_d, mag5_q;

  always_comb begin
    q4_ext = $signed({1'b0, q4_q});
    v5     = neg4_q ? -q4_ext : q4_ext;
    if (fahr4_q) v5 = v5 + F_OFFSET;
    err5_d = err4_q ||
             (fahr4_q ? (v5 > F_HIGH || v5 < F_LOW) : (v5 > C_LIMIT || v5 < -C_LIMIT));
    mag5_d = v5[13] ? 11'(-v5) : v5[10:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      err5_q  <= err5_d;
      fahr5_q <= fahr4_q;
      neg5_q  <= v5[13];
      mag5_q  <= mag5_d;
    end
  end

  // Stage 6: magnitude divided by ten
  logic        err6_q, fahr6_q, neg6_q;
  logic [26:0] prod6;
  logic [10:0] mag6_q;
  logic [6:0]  q1_6_q;

  assign prod6 = 27'(mag5_q) * 27'd52429;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      err6_q  <= err5_q;
      fahr6_q <= fahr5_q;
      neg6_q  <= neg5_q;
      mag6_q  <= mag5_q;
      q1_6_q  <= prod6[25:19];
    end
  end

  // Stage 7: tenths digit and magnitude divided by one hundred
  logic        err7_q, fahr7_q, neg7_q;
  logic [10:0] q1x10;
  logic [14:0] prod7;
  digit_t      d0_7_q;
  logic [6:0]  q1_7_q;
  logic [3:0]  q2_7_q;

  always_comb begin
    q1x10 = 11'({q1_6_q, 3'b000}) + 11'({q1_6_q, 1'b0});
    prod7 = 15'(q1_6_q) * 15'd205;
  end

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      err7_q  <= err6_q;
      fahr7_q <= fahr6_q;
      neg7_q  <= neg6_q;
      d0_7_q  <= 4'(mag6_q - q1x10);
      q1_7_q  <= q1_6_q;
      q2_7_q  <= prod7[14:11];
    end
  end

  // Stage 8: remaining digits and segment encoding
  logic [6:0]  q2x10;
  digit_t      d1, d2, d3;
  logic [29:0] word_d, word_q;
  logic        fault_q;

  always_comb begin
    q2x10 = 7'({q2_7_q, 3'b000}) + 7'({q2_7_q, 1'b0});
    d1    = 4'(q1_7_q - q2x10);
    d3    = (q2_7_q >= 4'd10) ? 4'd1 : 4'd0;
    d2    = (q2_7_q >= 4'd10) ? 4'(q2_7_q - 4'd10) : q2_7_q;

    word_d = '0;
    word_d[fahr7_q ? UNIT_F_BIT : UNIT_C_BIT] = 1'b1;
    if (d3 != '0) begin
      word_d[27:21] = seg7(d3);
    end else if (neg7_q && d2 != '0) begin
      word_d[27:21] = SEG_MINUS;
    end
    if (d2 != '0 || d3 != '0) begin
      word_d[20:14] = seg7(d2);
    end else if (neg7_q) begin
      word_d[20:14] = SEG_MINUS;
    end
    word_d[13:7] = seg7(d1);
    word_d[6:0]  = seg7(d0_7_q);
    if (err7_q) word_d = ERR_WORD;
  end

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      word_q  <= word_d;
      fault_q <= err7_q;
    end
  end

  assign out_valid_o    = valid_q[NSTAGE];
  assign display_word_o = word_q;
  assign fault_o        = fault_q;

endmodule

// File: design/tmsd_checker.sv
`include "assert_macros.svh"

module tmsd_checker
  import tmsd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [29:0] display_word_o,
  input logic        fault_o
);

  // A fault always shows the ERR pattern
  `ASSERT_IMPL(a_fault_err, clk_i, rst_ni, out_valid_o && fault_o, display_word_o == ERR_WORD)

  // A good reading carries exactly one unit mark
  `ASSERT_IMPL(a_unit_mark, clk_i, rst_ni, out_valid_o && !fault_o, $onehot(display_word_o[29:28]))

  // Input backs up only behind a stalled result
  `ASSERT_IMPL(a_stall_chain, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // Hold a stalled transaction
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(display_word_o) && $stable(fault_o))

endmodule

bind thermometer_seven_segment_display tmsd_checker u_tmsd_checker (.*);

// File: tb/tb_thermometer_seven_segment_display.sv
`timescale 1ns / 1ps

module tb_thermometer_seven_segment_display;
  import tmsd_pkg::*;

  // One reading as presented to the block
  typedef struct packed {
    logic [15:0] raw;
    logic [7:0]  status;
  } reading_t;

  // One predicted display result, with the reading that caused it
  typedef struct packed {
    logic [15:0] raw;
    logic [7:0]  status;
    logic [29:0] word;
    logic        fault;
  } shown_t;

  localparam logic [6:0] DIGIT_SEGS [10] = '{
    7'h7B, 7'h48, 7'h3D, 7'h6D, 7'h4E, 7'h67, 7'h77, 7'h49, 7'h7F, 7'h6F
  };
  localparam logic [29:0] ERR_SHOWN = {2'b00, SEG_E, SEG_R, SEG_R, 7'b0000000};
  localparam int N_RANDOM = 1400;
  localparam int TAIL_ITEMS = 150;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] sensor_value_i = '0;
  logic [7:0]  status_bits_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [29:0] display_word_o;
  logic        fault_o;

  reading_t reading_q[$];
  shown_t   shown_q[$];

  int n_sent = 0;
  int n_recv = 0;
  int n_errors = 0;
  int n_total = 0;
  int n_faults = 0;
  int n_fahr = 0;
  int idle_left = 0;
  int stall_left = 0;
  logic drain_hold = 1'b0;
  logic tail_phase = 1'b0;

  thermometer_seven_segment_display u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sensor_value_i (sensor_value_i),
    .status_bits_i  (status_bits_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .display_word_o (display_word_o),
    .fault_o        (fault_o)
  );

  // Free-running clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Work out the display word and fault flag for one reading
  function automatic void predict_display(input logic [15:0] raw, input logic [7:0] st,
                                          output logic [29:0] word, output logic fault);
    int   s;
    int   t;
    int   mag;
    int   d0, d1, d2, d3;
    logic fahr;
    logic neg;
    s = int'($signed(raw));
    fahr = st[5];
    word = ERR_SHOWN;
    fault = 1'b1;
    if (s < 0 || s > int'(SENSOR_MAX) || st[2]) return;
    t = (s >> 5) - int'(C_OFFSET);
    // round up on the upper half of the fraction
    if ((s & 31) >= 16) t = t + 1;
    // division truncates toward zero, as int division does
    if (fahr) t = (t * 9) / 5 + int'(F_OFFSET);
    if (!fahr && (t > int'(C_LIMIT) || t < -int'(C_LIMIT))) return;
    if (fahr && (t > int'(F_HIGH) || t < int'(F_LOW))) return;
    neg = (t < 0);
    mag = neg ? -t : t;
    d0 = mag % 10;
    d1 = (mag / 10) % 10;
    d2 = (mag / 100) % 10;
    d3 = (mag / 1000) % 10;
    word = '0;
    word[fahr ? UNIT_F_BIT : UNIT_C_BIT] = 1'b1;
    // blank leading zeros, then place the minus sign
    if (d3 != 0) word[27:21] = DIGIT_SEGS[d3];
    if (d2 != 0 || d3 != 0) word[20:14] = DIGIT_SEGS[d2];
    if (neg && d2 == 0 && d3 == 0) word[20:14] = word[20:14] | SEG_MINUS;
    else if (neg && d2 != 0 && d3 == 0) word[27:21] = word[27:21] | SEG_MINUS;
    word[13:7] = DIGIT_SEGS[d1];
    word[6:0] = DIGIT_SEGS[d0];
    fault = 1'b0;
  endfunction

  task automatic add_reading(input logic [15:0] raw, input logic [7:0] st);
    reading_t r;
    r.raw = raw;
    r.status = st;
    reading_q.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    n_errors++;
  endtask

  // Drive readings; record the prediction for every accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin : drive_readings
    reading_t nxt;
    shown_t   want;
    int       n_taken;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sensor_value_i <= '0;
      status_bits_i <= '0;
      idle_left <= 0;
      drain_hold <= 1'b0;
      tail_phase <= 1'b0;
      n_sent <= 0;
      n_taken = 0;
    end else begin
      tail_phase <= (reading_q.size() < TAIL_ITEMS);
      if (in_valid_i && !in_stall_o) begin
        want.raw = sensor_value_i;
        want.status = status_bits_i;
        predict_display(sensor_value_i, status_bits_i, want.word, want.fault);
        shown_q.push_back(want);
        if (want.fault) n_faults++;
        else if (status_bits_i[5]) n_fahr++;
        n_sent <= n_sent + 1;
      end
      // Present the next reading once the current one is gone
      if (!in_valid_i || !in_stall_o) begin
        if (idle_left != 0) begin
          idle_left <= idle_left - 1;
          in_valid_i <= 1'b0;
        end else if (drain_hold) begin
          in_valid_i <= 1'b0;
          if (!in_valid_i && n_recv == n_sent) drain_hold <= 1'b0;
        end else if (reading_q.size() != 0) begin
          nxt = reading_q.pop_front();
          sensor_value_i <= nxt.raw;
          status_bits_i <= nxt.status;
          in_valid_i <= 1'b1;
          n_taken++;
          // hold off until the pipeline has fully drained, twice per run
          if (n_taken == 25 || n_taken == 700) drain_hold <= 1'b1;
          else if (!tail_phase && $urandom_range(0, 7) == 0) idle_left <= $urandom_range(1, 15);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Check results against the oldest prediction; stall in random bursts
  always @(posedge clk_i or negedge rst_ni) begin : check_display
    shown_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
      n_recv <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (n_recv >= n_sent) begin
          report_mismatch($sformatf("result with nothing pending: word=%h fault=%b",
                                    display_word_o, fault_o));
        end else begin
          want = shown_q.pop_front();
          if (display_word_o !== want.word)
            report_mismatch($sformatf("raw=%h st=%h word got %h want %h",
                                      want.raw, want.status, display_word_o, want.word));
          if (fault_o !== want.fault)
            report_mismatch($sformatf("raw=%h st=%h fault got %b want %b",
                                      want.raw, want.status, fault_o, want.fault));
          n_recv <= n_recv + 1;
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 14);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : run_readings
    logic [7:0]  st;
    logic [15:0] raw;
    int          pick;
    // range edges, sign bit, out-of-range readings
    add_reading(16'd0, 8'h00);
    add_reading(16'd28800, 8'h00);
    add_reading(16'd28801, 8'h00);
    add_reading(16'hFFFF, 8'h00);
    add_reading(16'h8000, 8'h00);
    add_reading(16'h7FFF, 8'h00);
    // zero degrees, rounding boundary, low bits all set
    add_reading(16'd14400, 8'h00);
    add_reading(16'd14415, 8'h00);
    add_reading(16'd14416, 8'h00);
    add_reading(16'd31, 8'h00);
    // minus sign in the tens group, then in the hundreds group
    add_reading(16'd14240, 8'h00);
    add_reading(16'd10464, 8'h00);
    // Fahrenheit: freezing, top and bottom, truncation of negatives
    add_reading(16'd14400, 8'h20);
    add_reading(16'd28800, 8'h20);
    add_reading(16'd0, 8'h20);
    add_reading(16'd14304, 8'h20);
    add_reading(16'd8672, 8'h20);
    add_reading(16'd10464, 8'h20);
    // sensor error flag, ignored status bits
    add_reading(16'd20000, 8'h04);
    add_reading(16'd20000, 8'h24);
    add_reading(16'd20000, 8'hDB);
    add_reading(16'd20000, 8'hFF);
    add_reading(16'hFFFF, 8'h20);
    // random readings, mostly inside the valid range
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 19);
      st = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 19) < 17) st[2] = 1'b0;
      if (pick < 16) raw = 16'($urandom_range(0, 28800));
      else if (pick == 16) raw = 16'($urandom_range(0, 40)) - 16'd20;
      else if (pick == 17) raw = 16'($urandom_range(28780, 28820));
      else raw = 16'($urandom);
      add_reading(raw, st);
    end
    n_total = reading_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every reading to pass through, then let the pipeline settle
    do @(posedge clk_i); while (!(n_sent == n_total && n_recv == n_sent));
    repeat (30) @(posedge clk_i);
    if (shown_q.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", shown_q.size()));

    $display("Covered %0d readings: %0d shown as ERR, %0d in Fahrenheit,", n_total, n_faults,
             n_fahr);
    $display("with random idle and stall bursts and two full drains.");
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timeout: %0d of %0d readings sent, %0d results seen", n_sent, n_total, n_recv);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/tmsd_pkg.sv
design/thermometer_seven_segment_display.sv
design/tmsd_checker.sv
tb/tb_thermometer_seven_segment_display.sv
